[design/gcrq_pkg.sv]
// shared types and constants for the group commit ring queue
package gcrq_pkg;

    localparam int PKT_W  = 64;
    localparam int SLOT_W = 4;
    localparam int ACT_W  = 3;
    localparam int QLEN_W = 5;

    localparam logic [QLEN_W-1:0] QLEN_RESET = 5'd16;

    localparam logic [ACT_W-1:0] ACT_PUT     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_COMMIT  = 3'd1;
    localparam logic [ACT_W-1:0] ACT_GET     = 3'd2;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 3'd3;
    localparam logic [ACT_W-1:0] ACT_PEEK    = 3'd4;
    localparam logic [ACT_W-1:0] ACT_NEXT    = 3'd5;
    localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd6;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [PKT_W-1:0]  entry_data;
        logic [SLOT_W-1:0] slot_in;
    } item_in_t;

    typedef struct packed {
        logic              ok;
        logic [PKT_W-1:0]  out_data;
        logic [SLOT_W-1:0] out_slot;
    } item_out_t;

endpackage

[design/gcrq_slot_mem.sv]
// packet slot memory, one write port and one registered read port
module gcrq_slot_mem #(
    parameter int DEPTH       = 16,
    parameter int PACKET_BITS = 64,
    parameter int AW          = 4
) (
    input  logic                   clk,
    input  logic                   wr_en,
    input  logic [AW-1:0]          wr_addr,
    input  logic [PACKET_BITS-1:0] wr_data,
    input  logic                   rd_en,
    input  logic [AW-1:0]          rd_addr,
    output logic [PACKET_BITS-1:0] rd_data
);

    logic [PACKET_BITS-1:0] mem [DEPTH];
    logic [PACKET_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[design/group_commit_ring_queue.sv]
// group commit ring queue: the result is registered and appears in the cycle after its item is accepted
// throughput one item per cycle while the result side takes items; a put writes the slot memory,
// and every accepted item does a registered read, whose data is used for get, peek and next
// the slot memory read register is the output register and holds while stalled
// reset clears all pointers and counts and sets queue_length to 16
// slot contents are not cleared by reset or by clear
module group_commit_ring_queue
    import gcrq_pkg::*;
#(
    parameter int DEPTH       = 16,
    parameter int PACKET_BITS = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  item_in_t          in_item,
    output logic              out_valid,
    input  logic              out_stall,
    output item_out_t         out_item,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [QLEN_W-1:0] cfg_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int W     = (PTR_W + 1 > 6) ? PTR_W + 1 : 6;
    localparam logic [W-1:0] DEPTH_W = W'(DEPTH);

    logic [PTR_W-1:0]  prod_write_ptr_reg, prod_write_ptr_next;
    logic [PTR_W-1:0]  prod_read_ptr_reg, prod_read_ptr_next;
    logic [PTR_W-1:0]  cons_read_ptr_reg, cons_read_ptr_next;
    logic [PTR_W-1:0]  cons_write_ptr_reg, cons_write_ptr_next;
    logic [CNT_W-1:0]  used_count_reg, used_count_next;
    logic [CNT_W-1:0]  committed_count_reg, committed_count_next;
    logic [CNT_W-1:0]  pending_puts_reg, pending_puts_next;
    logic [CNT_W-1:0]  pending_gets_reg, pending_gets_next;
    logic [QLEN_W-1:0] queue_length_reg;

    logic              out_valid_reg, out_valid_next;
    logic              ok_reg, ok_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;
    logic              use_data_reg, use_data_next;

    logic                   accept;
    logic                   mem_we;
    logic [PTR_W-1:0]       mem_rd_addr;
    logic [PACKET_BITS-1:0] mem_rd_data;
    logic [W-1:0]           eff_len;

    function automatic logic [PTR_W-1:0] adv(input logic [PTR_W-1:0] p,
                                              input logic [W-1:0] n);
        logic [W-1:0] q;
        q = W'(p) + W'(1);
        return (q >= n) ? '0 : q[PTR_W-1:0];
    endfunction

    assign accept    = in_valid && !in_stall;
    assign in_stall  = out_valid_reg && out_stall;
    assign cfg_ready = 1'b1;

    // zero acts as one, anything above the built depth acts as the depth
    always_comb
    begin
        eff_len = W'(queue_length_reg);
        if (eff_len == '0)
        begin
            eff_len = W'(1);
        end
        if (eff_len > DEPTH_W)
        begin
            eff_len = DEPTH_W;
        end
    end

    always_comb
    begin
        logic [W-1:0] a;
        logic [W-1:0] cr;
        logic [W-1:0] pr;

        prod_write_ptr_next  = prod_write_ptr_reg;
        prod_read_ptr_next   = prod_read_ptr_reg;
        cons_read_ptr_next   = cons_read_ptr_reg;
        cons_write_ptr_next  = cons_write_ptr_reg;
        used_count_next      = used_count_reg;
        committed_count_next = committed_count_reg;
        pending_puts_next    = pending_puts_reg;
        pending_gets_next    = pending_gets_reg;
        mem_we               = 1'b0;
        mem_rd_addr          = prod_read_ptr_reg;
        ok_next              = 1'b0;
        slot_next            = '0;
        use_data_next        = 1'b0;

        cr = W'(cons_read_ptr_reg);
        pr = W'(prod_read_ptr_reg);

        // step inside the taken group, wrapping back to its start
        a = W'(in_item.slot_in) + W'(1);
        if (a >= eff_len)
        begin
            a = '0;
            if (cr == '0)
            begin
                a = pr;
            end
        end
        else if (cr > pr)
        begin
            if (a >= cr)
            begin
                a = pr;
            end
        end
        else if (a < pr)
        begin
            if (a >= cr)
            begin
                a = pr;
            end
        end
        if (a >= DEPTH_W)
        begin
            a = '0;
        end

        case (in_item.action)
            ACT_PUT:
            begin
                if (W'(used_count_reg) < eff_len)
                begin
                    mem_we              = accept;
                    prod_write_ptr_next = adv(prod_write_ptr_reg, eff_len);
                    used_count_next     = used_count_reg + CNT_W'(1);
                    pending_puts_next   = pending_puts_reg + CNT_W'(1);
                    ok_next             = 1'b1;
                end
            end
            ACT_COMMIT:
            begin
                cons_write_ptr_next  = prod_write_ptr_reg;
                committed_count_next = committed_count_reg + pending_puts_reg;
                pending_puts_next    = '0;
                ok_next              = 1'b1;
            end
            ACT_GET:
            begin
                if (committed_count_reg != '0)
                begin
                    mem_rd_addr          = cons_read_ptr_reg;
                    slot_next            = cr[SLOT_W-1:0];
                    use_data_next        = 1'b1;
                    cons_read_ptr_next   = adv(cons_read_ptr_reg, eff_len);
                    committed_count_next = committed_count_reg - CNT_W'(1);
                    pending_gets_next    = pending_gets_reg + CNT_W'(1);
                    ok_next              = 1'b1;
                end
            end
            ACT_RELEASE:
            begin
                prod_read_ptr_next = cons_read_ptr_reg;
                used_count_next    = (used_count_reg >= pending_gets_reg)
                                     ? used_count_reg - pending_gets_reg : '0;
                pending_gets_next  = '0;
                ok_next            = 1'b1;
            end
            ACT_PEEK:
            begin
                if (used_count_reg != '0)
                begin
                    mem_rd_addr   = prod_read_ptr_reg;
                    slot_next     = pr[SLOT_W-1:0];
                    use_data_next = 1'b1;
                    ok_next       = 1'b1;
                end
            end
            ACT_NEXT:
            begin
                mem_rd_addr   = a[PTR_W-1:0];
                slot_next     = a[SLOT_W-1:0];
                use_data_next = 1'b1;
                ok_next       = 1'b1;
            end
            ACT_CLEAR:
            begin
                prod_write_ptr_next  = '0;
                prod_read_ptr_next   = '0;
                cons_read_ptr_next   = '0;
                cons_write_ptr_next  = '0;
                used_count_next      = '0;
                committed_count_next = '0;
                pending_puts_next    = '0;
                pending_gets_next    = '0;
                ok_next              = 1'b1;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (accept)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_write_ptr_reg  <= '0;
            prod_read_ptr_reg   <= '0;
            cons_read_ptr_reg   <= '0;
            cons_write_ptr_reg  <= '0;
            used_count_reg      <= '0;
            committed_count_reg <= '0;
            pending_puts_reg    <= '0;
            pending_gets_reg    <= '0;
            queue_length_reg    <= QLEN_RESET;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                prod_write_ptr_reg  <= prod_write_ptr_next;
                prod_read_ptr_reg   <= prod_read_ptr_next;
                cons_read_ptr_reg   <= cons_read_ptr_next;
                cons_write_ptr_reg  <= cons_write_ptr_next;
                used_count_reg      <= used_count_next;
                committed_count_reg <= committed_count_next;
                pending_puts_reg    <= pending_puts_next;
                pending_gets_reg    <= pending_gets_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                queue_length_reg <= cfg_data;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    // result fields travel alongside the memory read register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg       <= ok_next;
            slot_reg     <= slot_next;
            use_data_reg <= use_data_next;
        end
    end

    gcrq_slot_mem #(
        .DEPTH       (DEPTH),
        .PACKET_BITS (PACKET_BITS),
        .AW          (PTR_W)
    ) u_slot_mem (
        .clk     (clk),
        .wr_en   (mem_we),
        .wr_addr (prod_write_ptr_reg),
        .wr_data (in_item.entry_data[PACKET_BITS-1:0]),
        .rd_en   (accept),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign out_valid         = out_valid_reg;
    assign out_item.ok       = ok_reg;
    assign out_item.out_slot = slot_reg;
    assign out_item.out_data = use_data_reg ? PKT_W'(mem_rd_data) : '0;

endmodule

[tb/sv/group_commit_ring_queue_tb.sv]
`timescale 1ns / 100ps
// self-checking testbench for the group commit ring queue: directed table, then random groups and single items
module group_commit_ring_queue_tb
    import gcrq_pkg::*;
;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 1800;
    localparam int IDLE_PCT     = 27;
    localparam int HOLD_START   = 1500;
    localparam int HOLD_LEN     = 90;
    localparam int CALM_START   = 2200;
    localparam int CALM_END     = 2700;
    localparam int CFG_EVERY    = 250;

    localparam logic [ACT_W-1:0] ACT_UNUSED = 3'd7;
    localparam logic [PKT_W-1:0] ALL_ONES   = {PKT_W{1'b1}};

    typedef struct {
        bit                is_cfg;
        logic [QLEN_W-1:0] cfg_val;
        item_in_t          op;
        bit                typed;
        item_out_t         want;
    } stim_row_t;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              in_valid  = 1'b0;
    logic              in_stall;
    item_in_t          in_item   = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    item_out_t         out_item;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [QLEN_W-1:0] cfg_data  = '0;

    // predictor copy of the queue
    logic [PKT_W-1:0]  slot_mem [DEPTH];
    bit                slot_written [DEPTH];
    logic [SLOT_W-1:0] prod_wr, prod_rd, cons_rd, cons_wr;
    logic [4:0]        used_cnt, commit_cnt, pend_puts, pend_gets;
    logic [QLEN_W-1:0] qlen;

    item_out_t expected_results [$];
    stim_row_t directed_rows [$];
    int        mismatches = 0;
    int        cycle_cnt  = 0;
    bit        no_idle    = 1'b0;

    group_commit_ring_queue #(
        .DEPTH       (DEPTH),
        .PACKET_BITS (PKT_W)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int eff_length();
        if (qlen == 0)
            return 1;
        if (qlen > DEPTH)
            return DEPTH;
        return int'(qlen);
    endfunction

    function automatic logic [SLOT_W-1:0] step_ptr(logic [SLOT_W-1:0] p);
        int q;
        q = int'(p) + 1;
        return (q >= eff_length()) ? '0 : q[SLOT_W-1:0];
    endfunction

    // slot reached by next-in-group, wrapping back to the start of the taken group
    function automatic int group_next(logic [SLOT_W-1:0] slot);
        int a;
        int cr;
        int pr;
        cr = int'(cons_rd);
        pr = int'(prod_rd);
        a  = int'(slot) + 1;
        if (a >= eff_length())
        begin
            a = 0;
            if (cr == 0)
                a = pr;
        end
        else if (cr > pr)
        begin
            if (a >= cr)
                a = pr;
        end
        else if (a < pr)
        begin
            if (a >= cr)
                a = pr;
        end
        if (a >= DEPTH)
            a = 0;
        return a;
    endfunction

    function automatic bit reads_unwritten(item_in_t op);
        case (op.action)
            ACT_GET:  return commit_cnt != 0 && !slot_written[cons_rd];
            ACT_PEEK: return used_cnt != 0 && !slot_written[prod_rd];
            ACT_NEXT: return !slot_written[group_next(op.slot_in)];
            default:  return 1'b0;
        endcase
    endfunction

    task automatic clear_ptrs();
        prod_wr    = '0;
        prod_rd    = '0;
        cons_rd    = '0;
        cons_wr    = '0;
        used_cnt   = '0;
        commit_cnt = '0;
        pend_puts  = '0;
        pend_gets  = '0;
    endtask

    task automatic predict_queue_op(input item_in_t op, output item_out_t res);
        int a;
        res = '0;
        case (op.action)
            ACT_PUT:
                if (used_cnt < eff_length())
                begin
                    slot_mem[prod_wr]     = op.entry_data;
                    slot_written[prod_wr] = 1'b1;
                    prod_wr               = step_ptr(prod_wr);
                    used_cnt++;
                    pend_puts++;
                    res.ok = 1'b1;
                end
            ACT_COMMIT:
            begin
                cons_wr    = prod_wr;
                commit_cnt = commit_cnt + pend_puts;
                pend_puts  = '0;
                res.ok     = 1'b1;
            end
            ACT_GET:
                if (commit_cnt != 0)
                begin
                    res.out_slot = cons_rd;
                    res.out_data = slot_mem[cons_rd];
                    cons_rd      = step_ptr(cons_rd);
                    commit_cnt--;
                    pend_gets++;
                    res.ok = 1'b1;
                end
            ACT_RELEASE:
            begin
                prod_rd   = cons_rd;
                used_cnt  = (used_cnt >= pend_gets) ? used_cnt - pend_gets : '0;
                pend_gets = '0;
                res.ok    = 1'b1;
            end
            ACT_PEEK:
                if (used_cnt != 0)
                begin
                    res.out_slot = prod_rd;
                    res.out_data = slot_mem[prod_rd];
                    res.ok       = 1'b1;
                end
            ACT_NEXT:
            begin
                a            = group_next(op.slot_in);
                res.out_slot = a[SLOT_W-1:0];
                res.out_data = slot_mem[a];
                res.ok       = 1'b1;
            end
            ACT_CLEAR:
            begin
                clear_ptrs();
                res.ok = 1'b1;
            end
            default: ;
        endcase
    endtask

    function automatic item_in_t make_op(logic [ACT_W-1:0] action);
        item_in_t op;
        int pick;
        pick = $urandom_range(0, 99);
        op.action     = action;
        op.entry_data = (pick < 8) ? ALL_ONES : (pick < 16) ? '0 : {$urandom, $urandom};
        op.slot_in    = SLOT_W'($urandom_range(0, 15));
        return op;
    endfunction

    // offer one item, hold it until taken, then record what it should produce
    task automatic send_op(input item_in_t op, input bit typed, input item_out_t want);
        item_out_t res;
        while (!no_idle && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        // never let a read land on a slot that was never written
        if (reads_unwritten(op))
            op.action = ACT_COMMIT;
        in_valid <= 1'b1;
        in_item  <= op;
        do @(posedge clk); while (in_stall);
        predict_queue_op(op, res);
        expected_results.push_back(typed ? want : res);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_qlen(input logic [QLEN_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        qlen = v;
    endtask

    task automatic row_item(input logic [ACT_W-1:0] action, input logic [PKT_W-1:0] data,
                            input logic [SLOT_W-1:0] slot);
        stim_row_t r;
        r = '{default: '0};
        r.op = '{action: action, entry_data: data, slot_in: slot};
        directed_rows.push_back(r);
    endtask

    task automatic row_typed(input logic [ACT_W-1:0] action, input logic [PKT_W-1:0] data,
                             input logic [SLOT_W-1:0] slot, input logic ok,
                             input logic [PKT_W-1:0] odata, input logic [SLOT_W-1:0] oslot);
        stim_row_t r;
        r = '{default: '0};
        r.op    = '{action: action, entry_data: data, slot_in: slot};
        r.typed = 1'b1;
        r.want  = '{ok: ok, out_data: odata, out_slot: oslot};
        directed_rows.push_back(r);
    endtask

    task automatic row_cfg(input logic [QLEN_W-1:0] v);
        stim_row_t r;
        r = '{default: '0};
        r.is_cfg  = 1'b1;
        r.cfg_val = v;
        directed_rows.push_back(r);
    endtask

    // result side: random stalls, one long hold-off, one calm stretch
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (!rst_n)
            out_stall <= 1'b0;
        else if (cycle_cnt >= HOLD_START && cycle_cnt < HOLD_START + HOLD_LEN)
            out_stall <= 1'b1;
        else if (cycle_cnt >= CALM_START && cycle_cnt < CALM_END)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin : result_check
        item_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result with no item waiting: ok=%0b data=%h slot=%0d",
                             out_item.ok, out_item.out_data, out_item.out_slot);
            end
            else
            begin
                want = expected_results.pop_front();
                if (out_item.ok !== want.ok || out_item.out_data !== want.out_data ||
                    out_item.out_slot !== want.out_slot)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: ok %0b/%0b data %h/%h slot %0d/%0d (exp/got)",
                                 want.ok, out_item.ok, want.out_data, out_item.out_data,
                                 want.out_slot, out_item.out_slot);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("group_commit_ring_queue_tb NOT OK");
        $finish;
    end

    initial
    begin
        int sent;
        int since_cfg;
        int cfg_phase;
        int n;
        int m;
        int k;
        bit paused;
        logic [QLEN_W-1:0] cfg_pick;

        for (int i = 0; i < DEPTH; i++)
        begin
            slot_mem[i]     = '0;
            slot_written[i] = 1'b0;
        end
        clear_ptrs();
        qlen = QLEN_RESET;

        // empty queue, unused action, empty commit and release, then three puts
        row_typed(ACT_PEEK, '0, 4'd0, 1'b0, '0, 4'd0);
        row_typed(ACT_GET, '0, 4'd0, 1'b0, '0, 4'd0);
        row_typed(ACT_UNUSED, ALL_ONES, 4'd15, 1'b0, '0, 4'd0);
        row_typed(ACT_COMMIT, '0, 4'd0, 1'b1, '0, 4'd0);
        row_typed(ACT_RELEASE, '0, 4'd0, 1'b1, '0, 4'd0);
        row_typed(ACT_PUT, ALL_ONES, 4'd15, 1'b1, '0, 4'd0);
        row_typed(ACT_PUT, '0, 4'd0, 1'b1, '0, 4'd0);
        row_typed(ACT_PUT, 64'hA5A5_5A5A_F00F_0FF0, 4'd7, 1'b1, '0, 4'd0);
        // puts stay hidden until commit
        row_typed(ACT_GET, '0, 4'd0, 1'b0, '0, 4'd0);
        row_typed(ACT_COMMIT, '0, 4'd0, 1'b1, '0, 4'd0);
        row_typed(ACT_GET, '0, 4'd0, 1'b1, ALL_ONES, 4'd0);
        row_typed(ACT_PEEK, '0, 4'd0, 1'b1, ALL_ONES, 4'd0);
        row_item(ACT_NEXT, '0, 4'd0);
        row_item(ACT_GET, '0, 4'd0);
        row_item(ACT_NEXT, '0, 4'd15);
        row_typed(ACT_RELEASE, '0, 4'd0, 1'b1, '0, 4'd0);
        row_item(ACT_PEEK, '0, 4'd0);
        // length zero acts as one slot: queue is full
        row_cfg(5'd0);
        row_typed(ACT_PUT, 64'h1, 4'd0, 1'b0, '0, 4'd0);
        row_typed(ACT_CLEAR, '0, 4'd0, 1'b1, '0, 4'd0);
        row_typed(ACT_PUT, 64'h0123_4567_89AB_CDEF, 4'd0, 1'b1, '0, 4'd0);
        row_typed(ACT_PUT, 64'h2, 4'd0, 1'b0, '0, 4'd0);
        row_typed(ACT_COMMIT, '0, 4'd0, 1'b1, '0, 4'd0);
        row_item(ACT_GET, '0, 4'd0);
        row_item(ACT_NEXT, '0, 4'd3);
        row_typed(ACT_RELEASE, '0, 4'd0, 1'b1, '0, 4'd0);
        // length above depth acts as depth
        row_cfg(5'd31);
        row_typed(ACT_CLEAR, '0, 4'd0, 1'b1, '0, 4'd0);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                write_qlen(directed_rows[i].cfg_val);
            else
                send_op(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].want);
        end

        sent      = 0;
        since_cfg = 0;
        cfg_phase = 0;
        paused    = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (since_cfg >= CFG_EVERY)
            begin
                case (cfg_phase)
                    0:       cfg_pick = 5'd1;
                    1:       cfg_pick = 5'd16;
                    2:       cfg_pick = 5'd0;
                    3:       cfg_pick = 5'd31;
                    default: cfg_pick = QLEN_W'($urandom_range(0, 31));
                endcase
                write_qlen(cfg_pick);
                cfg_phase++;
                since_cfg = 0;
                // sometimes keep the old pointers so they may sit past the new length
                if ($urandom_range(0, 1) != 0)
                    send_op(make_op(ACT_CLEAR), 1'b0, '0);
            end
            if (sent >= 500 && !paused)
            begin
                drain();
                paused = 1'b1;
            end
            no_idle = (sent >= 900 && sent < 1150);
            if ($urandom_range(0, 99) < 75)
            begin
                // one put-commit-get group with random content and sizes that may overrun the length
                n = $urandom_range(1, eff_length() + 1);
                m = $urandom_range(0, n + 1);
                k = $urandom_range(0, 3);
                repeat (n) send_op(make_op(ACT_PUT), 1'b0, '0);
                send_op(make_op(ACT_COMMIT), 1'b0, '0);
                repeat (m) send_op(make_op(ACT_GET), 1'b0, '0);
                repeat (k)
                    send_op(make_op($urandom_range(0, 1) ? ACT_PEEK : ACT_NEXT), 1'b0, '0);
                if ($urandom_range(0, 3) != 0)
                    send_op(make_op(ACT_RELEASE), 1'b0, '0);
                sent      += n + m + k + 2;
                since_cfg += n + m + k + 2;
            end
            else
            begin
                k = $urandom_range(1, 6);
                repeat (k) send_op(make_op(ACT_W'($urandom_range(0, 7))), 1'b0, '0);
                sent      += k;
                since_cfg += k;
            end
        end
        no_idle = 1'b0;

        drain();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("group_commit_ring_queue_tb OK");
        else
            $display("group_commit_ring_queue_tb NOT OK");
        $finish;
    end

endmodule
